>>> rtl/amcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amcw_pkg
// shared types and constants of the avi movie chunk walker: result kinds,
// error codes, container tags and the result record between core and top
// ----------------------------------------------------------------------------
package amcw_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_RIFF       = 4'd1,
        ERR_AVI        = 4'd2,
        ERR_LIST       = 4'd3,
        ERR_HDRL       = 4'd4,
        ERR_AVIH       = 4'd5,
        ERR_LIST_SIZE  = 4'd6,
        ERR_PERIOD     = 4'd7,
        ERR_MOVI       = 4'd8
    } err_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_AVI  = 32'h2049_5641;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [31:0] TAG_HDRL = 32'h6C72_6468;
    localparam logic [31:0] TAG_AVIH = 32'h6869_7661;
    localparam logic [31:0] TAG_MOVI = 32'h6976_6F6D;
    localparam logic [15:0] STREAM0  = 16'h3030;
    localparam logic [15:0] TYPE_DC  = 16'h6364;
    localparam logic [31:0] PAD_MASK = 32'hFFFF_FFFE;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] chunk_number;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
        logic [31:0] usec_per_frame;
        err_t        error_code;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/amcw_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amcw_core
// parse state and per-byte decode: assembles little-endian fields, checks
// header tags, follows the list chain to movi and walks its chunks
// ----------------------------------------------------------------------------
module amcw_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              first_byte,
    input  wire logic [31:0]       movie_length,
    output amcw_pkg::result_t      res
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SEEK   = 3'd1,
        PH_LIST   = 3'd2,
        PH_WALK   = 3'd3,
        PH_CHUNK  = 3'd4,
        PH_ENDING = 3'd5,
        PH_HALT   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_position_reg, byte_position_next;
    logic [31:0] field_word_reg, field_word_next;
    logic [31:0] header_list_size_reg, header_list_size_next;
    logic [31:0] next_list_start_reg, next_list_start_next;
    logic [31:0] current_list_size_reg, current_list_size_next;
    logic [31:0] movi_list_end_reg, movi_list_end_next;
    logic [31:0] next_chunk_start_reg, next_chunk_start_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_counter_reg, chunk_counter_next;

    // state as seen by this beat, restart folded in
    phase_t      ph, ph1;
    logic [31:0] pos, fw, hls, nls, cls, mle, ncs, tag, cnt;
    logic [31:0] base, rel, word, next_start;
    logic [1:0]  rel_lo;
    logic        whole, frame, fits;
    logic [33:0] chunk_end;

    always_comb
    begin
        ph  = first_byte ? PH_HEADER : phase_reg;
        pos = first_byte ? 32'd0 : byte_position_reg;
        fw  = first_byte ? 32'd0 : field_word_reg;
        hls = first_byte ? 32'd0 : header_list_size_reg;
        nls = first_byte ? 32'd0 : next_list_start_reg;
        cls = first_byte ? 32'd0 : current_list_size_reg;
        mle = first_byte ? 32'd0 : movi_list_end_reg;
        ncs = first_byte ? 32'd0 : next_chunk_start_reg;
        tag = first_byte ? 32'd0 : chunk_tag_reg;
        cnt = first_byte ? 32'd1 : chunk_counter_reg;

        phase_next             = ph;
        byte_position_next     = pos + 32'd1;
        field_word_next        = fw;
        header_list_size_next  = hls;
        next_list_start_next   = nls;
        current_list_size_next = cls;
        movi_list_end_next     = mle;
        next_chunk_start_next  = ncs;
        chunk_tag_next         = tag;
        chunk_counter_next     = cnt;

        res                = '0;
        res.kind           = amcw_pkg::KIND_HEADER;
        res.error_code     = amcw_pkg::ERR_NONE;

        ph1 = ph;
        if (ph == PH_SEEK)
        begin
            if (nls >= movie_length || nls < pos)
            begin
                ph1 = PH_HALT;
                phase_next = PH_HALT;
                res.valid = 1'b1;
                res.kind = amcw_pkg::KIND_ERROR;
                res.error_code = amcw_pkg::ERR_MOVI;
            end
            else if (nls == pos)
            begin
                ph1 = PH_LIST;
                phase_next = PH_LIST;
            end
        end
        else if (ph == PH_WALK && ncs == pos)
        begin
            ph1 = PH_CHUNK;
            phase_next = PH_CHUNK;
        end

        // field assembly
        base = (ph1 == PH_LIST) ? nls : ((ph1 == PH_CHUNK) ? ncs : 32'd0);
        rel = pos - base;
        rel_lo = rel[1:0];
        if (rel_lo == 2'd0)
            word = {24'd0, data_byte};
        else
            word = fw | ({24'd0, data_byte} << {rel_lo, 3'b000});
        whole = (rel_lo == 2'd3);

        chunk_end  = {2'b00, ncs} + 34'd8 + {2'b00, word};
        fits       = chunk_end < {2'b00, movie_length};
        next_start = (ncs + 32'd9 + word) & amcw_pkg::PAD_MASK;
        frame      = tag[15:0] == amcw_pkg::STREAM0 && tag[31:16] == amcw_pkg::TYPE_DC;

        unique case (ph1)
            PH_HEADER:
            begin
                field_word_next = word;
                if (whole)
                begin
                    unique case (pos[31:2])
                        30'd0:
                            if (word != amcw_pkg::TAG_RIFF)
                            begin
                                phase_next = PH_HALT;
                                res.valid = 1'b1;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_RIFF;
                            end
                        30'd2:
                            if (word != amcw_pkg::TAG_AVI)
                            begin
                                phase_next = PH_HALT;
                                res.valid = 1'b1;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_AVI;
                            end
                        30'd3:
                            if (word != amcw_pkg::TAG_LIST)
                            begin
                                phase_next = PH_HALT;
                                res.valid = 1'b1;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_LIST;
                            end
                        30'd4:
                        begin
                            header_list_size_next = word;
                            if (word == 32'd0)
                            begin
                                phase_next = PH_HALT;
                                res.valid = 1'b1;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_LIST_SIZE;
                            end
                        end
                        30'd5:
                            if (word != amcw_pkg::TAG_HDRL)
                            begin
                                phase_next = PH_HALT;
                                res.valid = 1'b1;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_HDRL;
                            end
                        30'd6:
                            if (word != amcw_pkg::TAG_AVIH)
                            begin
                                phase_next = PH_HALT;
                                res.valid = 1'b1;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_AVIH;
                            end
                        30'd8:
                        begin
                            res.valid = 1'b1;
                            if (word == 32'd0)
                            begin
                                phase_next = PH_HALT;
                                res.kind = amcw_pkg::KIND_ERROR;
                                res.error_code = amcw_pkg::ERR_PERIOD;
                            end
                            else
                            begin
                                next_list_start_next = hls + 32'd20;
                                phase_next = PH_SEEK;
                                res.kind = amcw_pkg::KIND_HEADER;
                                res.usec_per_frame = word;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_LIST:
            begin
                field_word_next = word;
                if (whole && rel == 32'd7)
                    current_list_size_next = word;
                else if (whole && rel == 32'd11)
                begin
                    if (word == amcw_pkg::TAG_MOVI)
                    begin
                        movi_list_end_next = nls + 32'd8 + cls;
                        next_chunk_start_next = nls + 32'd12;
                        chunk_counter_next = 32'd1;
                        phase_next = PH_WALK;
                    end
                    else
                    begin
                        next_list_start_next = nls + cls + 32'd8;
                        phase_next = PH_SEEK;
                    end
                end
            end
            PH_CHUNK:
            begin
                field_word_next = word;
                if (whole && rel == 32'd3)
                    chunk_tag_next = word;
                else if (whole)
                begin
                    if (!fits)
                    begin
                        phase_next = PH_HALT;
                        chunk_counter_next = 32'd1;
                        res.valid = 1'b1;
                        res.kind = amcw_pkg::KIND_END;
                    end
                    else
                    begin
                        chunk_counter_next = cnt + 32'd1;
                        next_chunk_start_next = next_start;
                        phase_next = PH_WALK;
                        if (next_start == mle)
                        begin
                            chunk_counter_next = 32'd1;
                            phase_next = frame ? PH_ENDING : PH_HALT;
                        end
                        if (frame)
                        begin
                            res.valid = 1'b1;
                            res.kind = amcw_pkg::KIND_FRAME;
                            res.chunk_number = cnt;
                            res.payload_offset = ncs + 32'd8;
                            res.payload_size = word;
                        end
                        else if (next_start == mle)
                        begin
                            res.valid = 1'b1;
                            res.kind = amcw_pkg::KIND_END;
                        end
                    end
                end
            end
            PH_ENDING:
            begin
                phase_next = PH_HALT;
                res.valid = 1'b1;
                res.kind = amcw_pkg::KIND_END;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_HEADER;
            byte_position_reg     <= 32'd0;
            field_word_reg        <= 32'd0;
            header_list_size_reg  <= 32'd0;
            next_list_start_reg   <= 32'd0;
            current_list_size_reg <= 32'd0;
            movi_list_end_reg     <= 32'd0;
            next_chunk_start_reg  <= 32'd0;
            chunk_tag_reg         <= 32'd0;
            chunk_counter_reg     <= 32'd1;
        end
        else if (step)
        begin
            phase_reg             <= phase_next;
            byte_position_reg     <= byte_position_next;
            field_word_reg        <= field_word_next;
            header_list_size_reg  <= header_list_size_next;
            next_list_start_reg   <= next_list_start_next;
            current_list_size_reg <= current_list_size_next;
            movi_list_end_reg     <= movi_list_end_next;
            next_chunk_start_reg  <= next_chunk_start_next;
            chunk_tag_reg         <= chunk_tag_next;
            chunk_counter_reg     <= chunk_counter_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/avi_mjpeg_chunk_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avi_mjpeg_chunk_walker
// walks an avi byte stream: checks the main header, finds the movi list and
// reports every 00dc video chunk with its number, payload offset and size
//
// usage
//   cfg channel: one beat writes movie_length; write it while the walker idles
//   in channel: one file byte per beat, first_byte set on the byte at offset 0
//   out channel: at most one result per input byte (header, frame, end, error)
//   path: an input beat lands in the input register, is decoded once the
//   output register is free or being emptied, and its result is then
//   registered in the output register, from which it is offered
//   throughput: one byte per cycle while out_ready holds, set by the
//   combinational decode between the input register and the output register
//   stall: while the output register holds an untaken result, the decode of
//   the byte behind it waits; one byte more is still taken into the input
//   register, then in_ready drops until out_ready returns
//   reset: all parse state cleared, movie_length is zero, both registers
//   empty; after an end or error result bytes are consumed silently until a
//   beat with first_byte restarts parsing
// ----------------------------------------------------------------------------
module avi_mjpeg_chunk_walker (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      chunk_number,
    output logic [31:0]      payload_offset,
    output logic [31:0]      payload_size,
    output logic [31:0]      usec_per_frame,
    output logic [3:0]       error_code
);

    logic [31:0]        movie_length_reg, movie_length_next;
    logic               in_valid_reg, in_valid_next;
    logic [7:0]         byte_reg, byte_next;
    logic               first_reg, first_next;
    logic               out_valid_reg, out_valid_next;
    amcw_pkg::result_t  result_reg, result_next;
    amcw_pkg::result_t  res;
    logic               step;

    // decode one byte when the output register is free or being emptied
    assign step      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    amcw_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (byte_reg),
        .first_byte   (first_reg),
        .movie_length (movie_length_reg),
        .res          (res)
    );

    always_comb
    begin
        movie_length_next = movie_length_reg;
        if (cfg_valid)
            movie_length_next = cfg_data;

        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        first_next    = first_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            byte_next     = data_byte;
            first_next    = first_byte;
        end
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (step)
        begin
            out_valid_next = res.valid;
            result_next    = res;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            movie_length_reg <= 32'd0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            movie_length_reg <= movie_length_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        first_reg  <= first_next;
        result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = result_reg.kind;
    assign chunk_number   = result_reg.chunk_number;
    assign payload_offset = result_reg.payload_offset;
    assign payload_size   = result_reg.payload_size;
    assign usec_per_frame = result_reg.usec_per_frame;
    assign error_code     = result_reg.error_code;

`ifndef ASSERT_OFF
    // error results carry a code, all other kinds carry none
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == amcw_pkg::KIND_ERROR |-> error_code != amcw_pkg::ERR_NONE)
        else $error("error result without error code");

    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != amcw_pkg::KIND_ERROR |-> error_code == amcw_pkg::ERR_NONE)
        else $error("error code on a non-error result");

    // frame numbering starts at one
    a_frame_num: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == amcw_pkg::KIND_FRAME |-> chunk_number != 32'd0)
        else $error("frame result with chunk number zero");

    // a byte waiting in the input register is never lost
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(byte_reg) && $stable(first_reg))
        else $error("pending input beat dropped");
`endif

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the avi movie chunk walker: builds avi byte streams
// (good headers, list chains, movi chunk walks, faults, truncations, restarts)
// and feeds them one byte per beat with random gaps and output stalls; a
// behavioural walker in the bench predicts every result, which is compared
// field by field with what the block delivers
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          SETTLE       = 8;
    localparam int          DRAIN_LIMIT  = 4000;
    localparam int          BYTE_TARGET  = 1500;
    localparam logic [31:0] TAG_FRAME    = {amcw_pkg::TYPE_DC, amcw_pkg::STREAM0};
    localparam logic [31:0] TAG_00DB     = 32'h6264_3030;
    localparam logic [31:0] TAG_01DC     = 32'h6364_3130;
    localparam logic [31:0] TAG_01WB     = 32'h6277_3130;
    localparam logic [31:0] TAG_INFO     = 32'h4F46_4E49;
    localparam logic [31:0] LEN_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        WK_HEADER,
        WK_SEEK,
        WK_LIST,
        WK_GAP,
        WK_CHUNK,
        WK_LAST,
        WK_HALTED
    } walk_phase_t;

    typedef struct packed {
        amcw_pkg::kind_t kind;
        logic [31:0]     number;
        logic [31:0]     offset;
        logic [31:0]     size;
        logic [31:0]     usec;
        amcw_pkg::err_t  code;
    } walk_result_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = '0;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  kind;
    logic [31:0] chunk_number;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [31:0] usec_per_frame;
    logic [3:0]  error_code;

    walk_result_t expected_results[$];
    logic [7:0]   movie_bytes[$];
    int           movi_size_at;
    int           mismatches = 0;
    int           sent_bytes = 0;
    int           hold_off   = 0;
    bit           calm       = 1'b0;

    // predictor state
    logic [31:0] wk_length;
    logic [31:0] wk_pos;
    logic [31:0] wk_word;
    logic [31:0] wk_hdr_size;
    logic [31:0] wk_list_start;
    logic [31:0] wk_list_size;
    logic [31:0] wk_movi_end;
    logic [31:0] wk_chunk_start;
    logic [31:0] wk_tag;
    logic [31:0] wk_count;
    logic [31:0] wk_period;
    walk_phase_t wk_phase;

    avi_mjpeg_chunk_walker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .chunk_number   (chunk_number),
        .payload_offset (payload_offset),
        .payload_size   (payload_size),
        .usec_per_frame (usec_per_frame),
        .error_code     (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void walk_restart();
        wk_pos         = '0;
        wk_phase       = WK_HEADER;
        wk_word        = '0;
        wk_hdr_size    = '0;
        wk_list_start  = '0;
        wk_list_size   = '0;
        wk_movi_end    = '0;
        wk_chunk_start = '0;
        wk_tag         = '0;
        wk_count       = 32'd1;
        wk_period      = '0;
    endfunction

    function automatic walk_result_t walk_result(input amcw_pkg::kind_t k,
                                                 input logic [31:0] n,
                                                 input logic [31:0] o, input logic [31:0] s,
                                                 input logic [31:0] u,
                                                 input amcw_pkg::err_t c);
        walk_result_t r;
        r.kind   = k;
        r.number = n;
        r.offset = o;
        r.size   = s;
        r.usec   = u;
        r.code   = c;
        return r;
    endfunction

    function automatic bit walk_fail(input amcw_pkg::err_t c, output walk_result_t r);
        wk_phase = WK_HALTED;
        r = walk_result(amcw_pkg::KIND_ERROR, '0, '0, '0, '0, c);
        return 1'b1;
    endfunction

    // little-endian word assembly, true on the last byte of the word
    function automatic bit walk_gather(input logic [31:0] rel, input logic [7:0] b);
        if (rel[1:0] == 2'd0)
            wk_word = {24'd0, b};
        else
            wk_word = wk_word | ({24'd0, b} << (8 * rel[1:0]));
        return rel[1:0] == 2'd3;
    endfunction

    function automatic bit walk_header(input logic [31:0] p, input logic [7:0] b,
                                       output walk_result_t r);
        r = walk_result(amcw_pkg::KIND_HEADER, '0, '0, '0, '0, amcw_pkg::ERR_NONE);
        if (!walk_gather(p, b))
            return 1'b0;
        case (p >> 2)
            32'd0: if (wk_word != amcw_pkg::TAG_RIFF) return walk_fail(amcw_pkg::ERR_RIFF, r);
            32'd2: if (wk_word != amcw_pkg::TAG_AVI) return walk_fail(amcw_pkg::ERR_AVI, r);
            32'd3: if (wk_word != amcw_pkg::TAG_LIST) return walk_fail(amcw_pkg::ERR_LIST, r);
            32'd4:
            begin
                wk_hdr_size = wk_word;
                if (wk_word == '0)
                    return walk_fail(amcw_pkg::ERR_LIST_SIZE, r);
            end
            32'd5: if (wk_word != amcw_pkg::TAG_HDRL) return walk_fail(amcw_pkg::ERR_HDRL, r);
            32'd6: if (wk_word != amcw_pkg::TAG_AVIH) return walk_fail(amcw_pkg::ERR_AVIH, r);
            32'd8:
            begin
                wk_period = wk_word;
                if (wk_word == '0)
                    return walk_fail(amcw_pkg::ERR_PERIOD, r);
                wk_list_start = 32'd12 + wk_hdr_size + 32'd8;
                wk_phase = WK_SEEK;
                r = walk_result(amcw_pkg::KIND_HEADER, '0, '0, '0, wk_period,
                                amcw_pkg::ERR_NONE);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void walk_list(input logic [31:0] p, input logic [7:0] b);
        logic [31:0] rel;
        rel = p - wk_list_start;
        if (!walk_gather(rel, b))
            return;
        if (rel == 32'd7)
            wk_list_size = wk_word;
        else if (rel == 32'd11)
        begin
            if (wk_word == amcw_pkg::TAG_MOVI)
            begin
                wk_movi_end    = wk_list_start + 32'd8 + wk_list_size;
                wk_chunk_start = wk_list_start + 32'd12;
                wk_count       = 32'd1;
                wk_phase       = WK_GAP;
            end
            else
            begin
                wk_list_start = wk_list_start + wk_list_size + 32'd8;
                wk_phase      = WK_SEEK;
            end
        end
    endfunction

    function automatic bit walk_chunk(input logic [31:0] p, input logic [7:0] b,
                                      output walk_result_t r);
        logic [31:0] start;
        logic [31:0] rel;
        logic [31:0] size;
        logic [31:0] num;
        logic [31:0] follow;
        logic [33:0] reach;
        bit          frame;
        r = walk_result(amcw_pkg::KIND_END, '0, '0, '0, '0, amcw_pkg::ERR_NONE);
        start = wk_chunk_start;
        rel = p - start;
        if (!walk_gather(rel, b))
            return 1'b0;
        if (rel == 32'd3)
        begin
            wk_tag = wk_word;
            return 1'b0;
        end
        size = wk_word;
        // fit check without wrap
        reach = {2'b00, start} + 34'd8 + {2'b00, size};
        if (reach >= {2'b00, wk_length})
        begin
            wk_phase = WK_HALTED;
            wk_count = 32'd1;
            return 1'b1;
        end
        frame = (wk_tag[15:0] == amcw_pkg::STREAM0) && (wk_tag[31:16] == amcw_pkg::TYPE_DC);
        follow = (start + 32'd8 + size + 32'd1) & amcw_pkg::PAD_MASK;
        num = wk_count;
        wk_count = wk_count + 32'd1;
        wk_chunk_start = follow;
        if (follow == wk_movi_end)
        begin
            wk_count = 32'd1;
            if (!frame)
            begin
                wk_phase = WK_HALTED;
                return 1'b1;
            end
            wk_phase = WK_LAST;
        end
        else
            wk_phase = WK_GAP;
        if (frame)
        begin
            r = walk_result(amcw_pkg::KIND_FRAME, num, start + 32'd8, size, '0,
                            amcw_pkg::ERR_NONE);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit walk_predict(input logic [7:0] b, input logic first,
                                        output walk_result_t r);
        logic [31:0] p;
        bit          got;
        got = 1'b0;
        r = walk_result(amcw_pkg::KIND_HEADER, '0, '0, '0, '0, amcw_pkg::ERR_NONE);
        if (first)
            walk_restart();
        p = wk_pos;
        wk_pos = wk_pos + 32'd1;
        if (wk_phase == WK_SEEK)
        begin
            if (wk_list_start >= wk_length || wk_list_start < p)
                return walk_fail(amcw_pkg::ERR_MOVI, r);
            if (wk_list_start == p)
                wk_phase = WK_LIST;
        end
        else if (wk_phase == WK_GAP && wk_chunk_start == p)
            wk_phase = WK_CHUNK;
        case (wk_phase)
            WK_HEADER: got = walk_header(p, b, r);
            WK_LIST:   walk_list(p, b);
            WK_CHUNK:  got = walk_chunk(p, b, r);
            WK_LAST:
            begin
                wk_phase = WK_HALTED;
                r = walk_result(amcw_pkg::KIND_END, '0, '0, '0, '0, amcw_pkg::ERR_NONE);
                got = 1'b1;
            end
            default: ;
        endcase
        return got;
    endfunction

    // movie image builders
    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            movie_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_fill(input int n);
        for (int i = 0; i < n; i++)
            movie_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_header(input logic [31:0] hdr_size, input logic [31:0] period,
                                       input int fill);
        movie_bytes.delete();
        put_word(amcw_pkg::TAG_RIFF);
        put_word($urandom);
        put_word(amcw_pkg::TAG_AVI);
        put_word(amcw_pkg::TAG_LIST);
        put_word(hdr_size);
        put_word(amcw_pkg::TAG_HDRL);
        put_word(amcw_pkg::TAG_AVIH);
        put_word($urandom);
        put_word(period);
        put_fill(fill);
    endfunction

    function automatic void put_list(input int size);
        put_word(amcw_pkg::TAG_LIST);
        put_word(size);
        put_word(TAG_INFO);
        put_fill(size - 4);
    endfunction

    function automatic void open_movi();
        put_word(amcw_pkg::TAG_LIST);
        movi_size_at = movie_bytes.size();
        put_word('0);
        put_word(amcw_pkg::TAG_MOVI);
    endfunction

    function automatic void put_chunk(input logic [31:0] tag, input int size);
        put_word(tag);
        put_word(size);
        put_fill(size);
        if (size % 2 != 0)
            put_fill(1);
    endfunction

    function automatic void close_movi();
        logic [31:0] len;
        len = movie_bytes.size() - movi_size_at - 4;
        for (int i = 0; i < 4; i++)
            movie_bytes[movi_size_at + i] = len[8*i +: 8];
    endfunction

    function automatic void build_random_movie();
        int          fill;
        int          pick;
        logic [31:0] tag;
        fill = $urandom_range(0, 24);
        put_header(16 + fill, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom, fill);
        repeat ($urandom_range(0, 2))
            put_list($urandom_range(4, 20));
        open_movi();
        repeat ($urandom_range(1, 8))
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                6:       tag = TAG_01WB;
                7:       tag = TAG_00DB;
                8:       tag = TAG_01DC;
                9:       tag = $urandom;
                default: tag = TAG_FRAME;
            endcase
            put_chunk(tag, ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200)
                                                       : $urandom_range(0, 24));
        end
        close_movi();
        put_fill($urandom_range(1, 8));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int           gap;
        walk_result_t r;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_bytes++;
        if (walk_predict(b, first, r))
            expected_results.push_back(r);
    endtask

    task automatic send_movie();
        for (int i = 0; i < movie_bytes.size(); i++)
            send_byte(movie_bytes[i], i == 0);
    endtask

    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
            expected_results.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_movie_length(input logic [31:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        wk_length = len;
    endtask

    task automatic test_header_checks();
        amcw_pkg::err_t faults[7] = '{amcw_pkg::ERR_RIFF, amcw_pkg::ERR_AVI,
                                      amcw_pkg::ERR_LIST, amcw_pkg::ERR_HDRL,
                                      amcw_pkg::ERR_AVIH, amcw_pkg::ERR_LIST_SIZE,
                                      amcw_pkg::ERR_PERIOD};
        int   at;
        bit   zero;
        set_movie_length(LEN_MAX);
        foreach (faults[i])
        begin
            put_header(32'd16, 32'd40000, 0);
            zero = 1'b0;
            case (faults[i])
                amcw_pkg::ERR_RIFF:      at = 0;
                amcw_pkg::ERR_AVI:       at = 8;
                amcw_pkg::ERR_LIST:      at = 12;
                amcw_pkg::ERR_HDRL:      at = 20;
                amcw_pkg::ERR_AVIH:      at = 24;
                amcw_pkg::ERR_LIST_SIZE: begin at = 16; zero = 1'b1; end
                default:                 begin at = 32; zero = 1'b1; end
            endcase
            if (zero)
                for (int k = 0; k < 4; k++)
                    movie_bytes[at + k] = 8'h00;
            else
                movie_bytes[at] ^= 8'h20;
            put_fill(3);
            send_movie();
        end
    endtask

    task automatic test_frame_walk();
        set_movie_length(LEN_MAX);
        // last chunk a frame, end follows on the next byte
        put_header(32'd20, 32'd33367, 4);
        open_movi();
        put_chunk(TAG_FRAME, 0);
        put_chunk(TAG_FRAME, 5);
        put_chunk(TAG_01WB, 3);
        put_chunk(TAG_00DB, 2);
        put_chunk(TAG_01DC, 1);
        put_chunk(TAG_FRAME, 1);
        close_movi();
        put_fill(4);
        send_movie();
        // last chunk not a frame
        put_header(32'd16, LEN_MAX, 0);
        open_movi();
        put_chunk(TAG_FRAME, 7);
        put_chunk(TAG_01WB, 4);
        close_movi();
        put_fill(2);
        send_movie();
    endtask

    task automatic test_list_chain();
        put_header(32'd16, 32'd1, 0);
        put_list(4);
        put_list(9);
        open_movi();
        put_chunk(TAG_FRAME, 3);
        close_movi();
        put_fill(4);
        send_movie();
        // next list at the movie end
        put_header(32'd24, 32'd1000, 8);
        put_list(12);
        put_list(6);
        set_movie_length(movie_bytes.size());
        put_fill(4);
        send_movie();
        // list size that wraps the next start backwards
        set_movie_length(LEN_MAX);
        put_header(32'd16, 32'd500, 0);
        put_list(8);
        put_word(amcw_pkg::TAG_LIST);
        put_word(32'hFFFF_FFF0);
        put_word(TAG_INFO);
        put_fill(8);
        send_movie();
        // header list size that wraps
        put_header(32'hFFFF_FFF0, 32'd500, 8);
        send_movie();
    endtask

    task automatic test_truncation();
        int len;
        put_header(32'd16, 32'd2000, 0);
        open_movi();
        put_chunk(TAG_FRAME, 6);
        put_chunk(TAG_FRAME, 10);
        put_chunk(TAG_FRAME, 4);
        close_movi();
        put_fill(4);
        set_movie_length(movie_bytes.size() - 12);
        send_movie();
        // chunk ending exactly at the movie length
        put_header(32'd16, 32'd2000, 0);
        open_movi();
        put_chunk(TAG_FRAME, 4);
        close_movi();
        set_movie_length(movie_bytes.size());
        send_movie();
        // size far past the end
        set_movie_length(LEN_MAX);
        put_header(32'd16, 32'd2000, 0);
        open_movi();
        put_word(TAG_FRAME);
        put_word(32'hFFFF_FFF0);
        put_fill(8);
        close_movi();
        send_movie();
        // list end missed by the padded walk
        put_header(32'd16, 32'd2000, 0);
        open_movi();
        put_chunk(TAG_FRAME, 3);
        put_chunk(TAG_FRAME, 2);
        close_movi();
        len = movie_bytes[movi_size_at] + 2;
        movie_bytes[movi_size_at] = 8'(len);
        put_fill(12);
        send_movie();
    endtask

    task automatic test_zero_length();
        set_movie_length('0);
        put_header(32'd16, 32'd1, 0);
        open_movi();
        put_chunk(TAG_FRAME, 2);
        close_movi();
        send_movie();
    endtask

    task automatic test_restart();
        set_movie_length(LEN_MAX);
        put_header(32'd16, 32'd41666, 0);
        open_movi();
        put_chunk(TAG_FRAME, 9);
        put_chunk(TAG_FRAME, 2);
        close_movi();
        put_fill(3);
        for (int i = 0; i < movie_bytes.size() / 2; i++)
            send_byte(movie_bytes[i], i == 0);
        send_movie();
    endtask

    task automatic test_backpressure();
        set_movie_length(LEN_MAX);
        put_header(32'd16, 32'd20000, 0);
        open_movi();
        repeat (6)
            put_chunk(TAG_FRAME, $urandom_range(0, 6));
        close_movi();
        put_fill(4);
        calm = 1'b1;
        hold_off = 400;
        send_movie();
        calm = 1'b0;
    endtask

    task automatic test_random_movies();
        int pick;
        int cut;
        while (sent_bytes < BYTE_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else
            begin
                build_random_movie();
                if ($urandom_range(0, 5) == 0)
                    movie_bytes[$urandom_range(0, movie_bytes.size() - 1)]
                        ^= 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1) == 0)
                begin
                    pick = $urandom_range(0, 5);
                    if (pick == 0)
                        set_movie_length(LEN_MAX);
                    else if (pick == 1)
                        set_movie_length(movie_bytes.size() - $urandom_range(1, 40));
                    else
                        set_movie_length(movie_bytes.size() + $urandom_range(0, 3));
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    cut = $urandom_range(1, movie_bytes.size() - 1);
                    for (int i = 0; i < cut; i++)
                        send_byte(movie_bytes[i], i == 0);
                end
                send_movie();
            end
        end
        calm = 1'b0;
    endtask

    // output side stalls
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                quiet = hold_off;
                hold_off = 0;
            end
            else if (out_valid && out_ready)
                quiet = calm ? 0 : $urandom_range(0, 9);
            else if (quiet > 0)
                quiet--;
            out_ready <= (quiet == 0);
        end
    end

    // result beat check
    initial
    begin
        walk_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat, kind %0d", kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        mismatches++;
                    end
                    if (chunk_number !== want.number)
                    begin
                        $error("chunk_number: expected %0h, got %0h", want.number, chunk_number);
                        mismatches++;
                    end
                    if (payload_offset !== want.offset)
                    begin
                        $error("payload_offset: expected %0h, got %0h", want.offset,
                               payload_offset);
                        mismatches++;
                    end
                    if (payload_size !== want.size)
                    begin
                        $error("payload_size: expected %0h, got %0h", want.size, payload_size);
                        mismatches++;
                    end
                    if (usec_per_frame !== want.usec)
                    begin
                        $error("usec_per_frame: expected %0h, got %0h", want.usec,
                               usec_per_frame);
                        mismatches++;
                    end
                    if (error_code !== want.code)
                    begin
                        $error("error_code: expected %0d, got %0d", want.code, error_code);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        wk_length = '0;
        walk_restart();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_checks();
        test_frame_walk();
        test_list_chain();
        test_truncation();
        test_zero_length();
        test_restart();
        test_backpressure();
        test_random_movies();
        drain();
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> avi_mjpeg_chunk_walker.f
rtl/amcw_pkg.sv
rtl/amcw_core.sv
rtl/avi_mjpeg_chunk_walker.sv
dv/tb_top.sv
